// File: hdl/dmchp_pkg.sv
// Shared constants, types and helpers of the direct-mapped cache hit profiler.
package dmchp_pkg;

  // Lines in the tag store.
  localparam int LINE_COUNT = 128;
  // Widest index that fits the store: largest k with 2^k <= LINE_COUNT.
  localparam int IDX_W = $clog2(LINE_COUNT + 1) - 1;
  localparam int LINE_DEPTH = 1 << IDX_W;
  // Wide enough to hold a visit count up to 2^IDX_W.
  localparam int K_W = IDX_W + 1;

  localparam int ADDR_W = 32;
  localparam int CNT_W = 64;
  // A fetch count is a 32-bit repeat count plus one.
  localparam int RUN_W = 33;
  localparam int SPAN_W = 35;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADDR_W-1:0] FETCH_STEP = 32'd4;
  localparam logic [ADDR_W-1:0] LINE_STEP = 32'd1;
  localparam logic [ADDR_W-1:0] ADDR_ONES = 32'hFFFF_FFFF;
  localparam logic [IDX_W-1:0] IDX_ONES = {IDX_W{1'b1}};

  // Configuration register indexes.
  localparam logic REG_OFFSET_BITS = 1'b0;
  localparam logic REG_INDEX_BITS = 1'b1;

  typedef struct packed {
    logic [2:0] offset_bits;
    logic [2:0] index_bits;
  } cfg_t;

  // One classified record, ready for the tag store sequencer.
  typedef struct packed {
    logic [ADDR_W-1:0] cursor_a;
    logic [ADDR_W-1:0] cursor_b;
    logic [K_W-1:0] k;
    logic b_needed;
    logic [RUN_W-1:0] fetches;
    logic [RUN_W-1:0] base_hits;
    logic [2:0] n;
    logic [2:0] m;
    logic last;
  } desc_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] hits;
    logic done;
  } result_t;

  // Index width in use, saturated to what the store holds.
  function automatic logic [2:0] eff_index_bits(input logic [2:0] ib);
    logic [2:0] r;
    if (int'(ib) > IDX_W) begin
      r = 3'(IDX_W);
    end else begin
      r = ib;
    end
    return r;
  endfunction

endpackage

// File: hdl/direct_mapped_cache_hit_profiler_core.sv
// Top level of the direct-mapped cache hit profiler: config, front, queue, back, result buffer.
//
// Channel   Direction  Handshake                 Payload
// record    in         push / full               start_pc, repeat_count, last_record
// result    out        empty / pop               total_fetches, hit_fetches, trace_done
// config    in         cfg_write                 cfg_index, cfg_data
//
// The front end classifies a record through its span, size and k-select states, then
// pushes it. The back end then makes k visits, and k more when the run wraps the store,
// where k is the smaller of the lines visited and the distinct indexes a run can reach,
// over its single tag store port pair. Reset is immediate: per-line valid bits clear the tag store.
// A two-entry buffer on each side lets front and back stall independently.
module direct_mapped_cache_hit_profiler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] start_pc,
  input  logic [31:0] repeat_count,
  input  logic        last_record,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] total_fetches,
  output logic [63:0] hit_fetches,
  output logic        trace_done,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  dmchp_pkg::cfg_t cfg;

  logic q_full;
  logic q_empty;
  logic desc_push;
  logic desc_pop;
  dmchp_pkg::desc_t desc_in;
  dmchp_pkg::desc_t desc_out;

  dmchp_pkg::result_t res;
  logic res_push;
  logic res_full;

  dmchp_pkg::result_t res_slots [dmchp_pkg::QUEUE_DEPTH];
  logic [dmchp_pkg::QPTR_W-1:0] res_wr_ptr;
  logic [dmchp_pkg::QPTR_W-1:0] res_rd_ptr;
  logic [dmchp_pkg::QCNT_W-1:0] res_count;
  logic res_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_bits <= 3'd2;
      cfg.index_bits <= 3'd7;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dmchp_pkg::REG_OFFSET_BITS: cfg.offset_bits <= cfg_data;
        dmchp_pkg::REG_INDEX_BITS: cfg.index_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  dmchp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .start_pc     (start_pc),
    .repeat_count (repeat_count),
    .last_record  (last_record),
    .cfg          (cfg),
    .q_full       (q_full),
    .desc_push    (desc_push),
    .desc         (desc_in)
  );

  dmchp_desc_q u_desc_q (
    .clk   (clk),
    .rst   (rst),
    .push  (desc_push),
    .din   (desc_in),
    .full  (q_full),
    .pop   (desc_pop),
    .dout  (desc_out),
    .empty (q_empty)
  );

  dmchp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (desc_out),
    .desc_empty (q_empty),
    .desc_pop   (desc_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // Result buffer: the oldest result stays on the ports until it is popped.
  assign res_full = (res_count == dmchp_pkg::QCNT_W'(dmchp_pkg::QUEUE_DEPTH));
  assign empty = (res_count == '0);
  assign res_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= '0;
      res_rd_ptr <= '0;
      res_count <= '0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= (res_wr_ptr == dmchp_pkg::QPTR_W'(dmchp_pkg::QUEUE_DEPTH - 1))
                      ? '0 : res_wr_ptr + 1'b1;
      end
      if (res_pop) begin
        res_rd_ptr <= (res_rd_ptr == dmchp_pkg::QPTR_W'(dmchp_pkg::QUEUE_DEPTH - 1))
                      ? '0 : res_rd_ptr + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_count <= res_count + 1'b1;
      end else if (res_pop && !res_push) begin
        res_count <= res_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_slots[res_wr_ptr] <= res;
    end
  end

  assign total_fetches = res_slots[res_rd_ptr].total;
  assign hit_fetches = res_slots[res_rd_ptr].hits;
  assign trace_done = res_slots[res_rd_ptr].done;

endmodule

// File: hdl/dmchp_front.sv
// Front end: accepts trace records and works out the visit plan for each one.
module dmchp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [31:0]              start_pc,
  input  logic [31:0]              repeat_count,
  input  logic                     last_record,
  input  dmchp_pkg::cfg_t          cfg,
  input  logic                     q_full,
  output logic                     desc_push,
  output dmchp_pkg::desc_t         desc
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SPAN = 3'd1;
  localparam logic [2:0] F_SIZE = 3'd2;
  localparam logic [2:0] F_KSEL = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0] fstate;
  logic [2:0] fstate_next;

  logic [31:0] start_q;
  logic [31:0] rep_q;
  logic last_q;
  logic [2:0] n_q;
  logic [2:0] m_q;
  logic [dmchp_pkg::SPAN_W-1:0] span_q;
  logic [dmchp_pkg::RUN_W-1:0] visits_q;
  logic [dmchp_pkg::K_W-1:0] period_q;
  logic [dmchp_pkg::K_W-1:0] k_q;
  logic [dmchp_pkg::RUN_W-1:0] v0_q;
  logic b_q;
  logic [dmchp_pkg::RUN_W-1:0] base_q;

  logic wide_line;
  logic [dmchp_pkg::RUN_W-1:0] fetches;
  logic [dmchp_pkg::RUN_W-1:0] period_ext;
  logic [2:0] sh_raw;
  logic [2:0] sh;
  logic [dmchp_pkg::K_W-1:0] period;
  logic [31:0] line_first;

  assign wide_line = (n_q >= 3'd2);
  assign fetches = {1'b0, rep_q} + dmchp_pkg::RUN_W'(1);
  assign period_ext = dmchp_pkg::RUN_W'(period_q);
  assign line_first = start_q >> n_q;

  // With lines narrower than a fetch step, consecutive fetches skip indexes.
  always_comb begin
    sh_raw = (n_q == 3'd0) ? 3'd2 : 3'd1;
    sh = (sh_raw > m_q) ? m_q : sh_raw;
    if (wide_line) begin
      period = dmchp_pkg::K_W'(1) << m_q;
    end else begin
      period = (dmchp_pkg::K_W'(1) << m_q) >> sh;
    end
  end

  always_comb begin
    fstate_next = fstate;
    unique case (fstate)
      F_IDLE: if (push) fstate_next = F_SPAN;
      F_SPAN: fstate_next = F_SIZE;
      F_SIZE: fstate_next = F_KSEL;
      F_KSEL: fstate_next = F_PUSH;
      F_PUSH: if (!q_full) fstate_next = F_IDLE;
      default: fstate_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
    end else begin
      fstate <= fstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && push) begin
      start_q <= start_pc;
      rep_q <= repeat_count;
      last_q <= last_record;
      n_q <= cfg.offset_bits;
      m_q <= dmchp_pkg::eff_index_bits(cfg.index_bits);
    end
    if (fstate == F_SPAN) begin
      // Byte address of the last fetch, without wrapping.
      span_q <= {3'b000, start_q} + {1'b0, rep_q, 2'b00};
      period_q <= period;
    end
    if (fstate == F_SIZE) begin
      if (wide_line) begin
        visits_q <= dmchp_pkg::RUN_W'((span_q >> n_q)
                    - ({3'b000, start_q} >> n_q) + dmchp_pkg::SPAN_W'(1));
      end else begin
        visits_q <= fetches;
      end
    end
    if (fstate == F_KSEL) begin
      if (visits_q < period_ext) begin
        k_q <= dmchp_pkg::K_W'(visits_q);
        v0_q <= '0;
      end else begin
        k_q <= period_q;
        v0_q <= visits_q - period_ext;
      end
      b_q <= (visits_q > period_ext);
      base_q <= fetches - visits_q;
    end
  end

  assign full = (fstate != F_IDLE);
  assign desc_push = (fstate == F_PUSH) && !q_full;

  always_comb begin
    desc.cursor_a = wide_line ? line_first : start_q;
    desc.cursor_b = wide_line ? (line_first + v0_q[31:0])
                              : (start_q + {v0_q[29:0], 2'b00});
    desc.k = k_q;
    desc.b_needed = b_q;
    desc.fetches = fetches;
    desc.base_hits = base_q;
    desc.n = n_q;
    desc.m = m_q;
    desc.last = last_q;
  end

endmodule

// File: hdl/dmchp_desc_q.sv
// Short queue of visit plans between the front end and the tag store sequencer.
module dmchp_desc_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dmchp_pkg::desc_t  din,
  output logic              full,
  input  logic              pop,
  output dmchp_pkg::desc_t  dout,
  output logic              empty
);

  dmchp_pkg::desc_t slots [dmchp_pkg::QUEUE_DEPTH];
  logic [dmchp_pkg::QPTR_W-1:0] wr_ptr;
  logic [dmchp_pkg::QPTR_W-1:0] rd_ptr;
  logic [dmchp_pkg::QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full = (count == dmchp_pkg::QCNT_W'(dmchp_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == dmchp_pkg::QPTR_W'(dmchp_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == dmchp_pkg::QPTR_W'(dmchp_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// File: hdl/dmchp_back.sv
// Back end: walks the visits of one record through the tag store and keeps the totals.
module dmchp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  dmchp_pkg::desc_t     desc,
  input  logic                 desc_empty,
  output logic                 desc_pop,
  output dmchp_pkg::result_t   res,
  output logic                 res_push,
  input  logic                 res_full
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_RUN_A  = 3'd1;
  localparam logic [2:0] B_RUN_B  = 3'd2;
  localparam logic [2:0] B_FINISH = 3'd3;
  localparam logic [2:0] B_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  dmchp_pkg::desc_t d;
  logic [dmchp_pkg::K_W-1:0] cnt;
  logic [31:0] cursor;
  logic [dmchp_pkg::RUN_W-1:0] hit_acc;
  logic [dmchp_pkg::CNT_W-1:0] fetch_counter;
  logic [dmchp_pkg::CNT_W-1:0] hit_counter;

  logic [31:0] mem [dmchp_pkg::LINE_DEPTH];
  logic [dmchp_pkg::LINE_DEPTH-1:0] line_valid;
  logic [31:0] rdata;
  logic vbit;

  logic s1_valid;
  logic s1_cmp;
  logic s1_wr;
  logic [dmchp_pkg::IDX_W-1:0] s1_idx;
  logic [31:0] s1_tag;

  logic issue;
  logic cnt_last;
  logic [31:0] s0_line;
  logic [dmchp_pkg::IDX_W-1:0] s0_idx;
  logic [31:0] s0_tag;
  logic [31:0] stored;
  logic s1_hit;
  logic [dmchp_pkg::CNT_W-1:0] total_sum;
  logic [dmchp_pkg::CNT_W-1:0] hits_sum;

  assign issue = (state == B_RUN_A) || (state == B_RUN_B);
  assign cnt_last = (cnt == d.k - dmchp_pkg::K_W'(1));

  // Line, index and tag of the visit being issued.
  always_comb begin
    s0_line = (d.n >= 3'd2) ? cursor : (cursor >> d.n);
    s0_idx = s0_line[dmchp_pkg::IDX_W-1:0] & ~(dmchp_pkg::IDX_ONES << d.m);
    s0_tag = (s0_line >> d.m) & (dmchp_pkg::ADDR_ONES >> (4'(d.m) + 4'(d.n)));
  end

  // An entry never written reads as its cleared value.
  assign stored = vbit ? rdata : '0;
  assign s1_hit = s1_valid && s1_cmp && (stored == s1_tag);

  assign total_sum = fetch_counter + dmchp_pkg::CNT_W'(d.fetches);
  assign hits_sum = hit_counter + dmchp_pkg::CNT_W'(hit_acc);

  assign desc_pop = (state == B_IDLE) && !desc_empty;
  assign res_push = (state == B_DONE) && !res_full;
  assign res.total = total_sum;
  assign res.hits = hits_sum;
  assign res.done = d.last;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!desc_empty) state_next = B_RUN_A;
      B_RUN_A: begin
        if (cnt_last) state_next = d.b_needed ? B_RUN_B : B_FINISH;
      end
      B_RUN_B: if (cnt_last) state_next = B_FINISH;
      B_FINISH: state_next = B_DONE;
      B_DONE: if (!res_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      s1_valid <= 1'b0;
      line_valid <= '0;
      fetch_counter <= '0;
      hit_counter <= '0;
    end else begin
      state <= state_next;
      s1_valid <= issue;
      if (s1_valid && s1_wr) begin
        line_valid[s1_idx] <= 1'b1;
      end
      if (res_push) begin
        fetch_counter <= total_sum;
        hit_counter <= hits_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      d <= desc;
      cursor <= desc.cursor_a;
      cnt <= '0;
      hit_acc <= desc.base_hits;
    end else begin
      if (issue) begin
        // The tail pass restarts at the first of the last k visits.
        if (state == B_RUN_A && cnt_last) begin
          cursor <= d.cursor_b;
          cnt <= '0;
        end else begin
          cursor <= cursor + ((d.n >= 3'd2) ? dmchp_pkg::LINE_STEP
                                            : dmchp_pkg::FETCH_STEP);
          cnt <= cnt + 1'b1;
        end
      end
      if (s1_hit) begin
        hit_acc <= hit_acc + dmchp_pkg::RUN_W'(1);
      end
    end
    s1_cmp <= (state == B_RUN_A);
    s1_wr <= (state == B_RUN_B) || (state == B_RUN_A && !d.b_needed);
    s1_idx <= s0_idx;
    s1_tag <= s0_tag;
  end

  // Tag store: one read and one write port, read data registered.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_wr) begin
      mem[s1_idx] <= s1_tag;
    end
    rdata <= mem[s0_idx];
    vbit <= line_valid[s0_idx];
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN_A || state == B_RUN_B) |-> (cnt < d.k))
    else $error("visit counter ran past the visit count");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (issue && s1_valid && s1_wr) |-> (s0_idx != s1_idx))
    else $error("tag read and write hit the same index in one cycle");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE) |-> (hit_acc <= d.fetches))
    else $error("record hit count exceeds its fetch count");

endmodule
